FILE: rtl/core/brf_pkg.sv
// Shared types, constants and helper functions of the byte ring FIFO.
`default_nettype none

package brf_pkg;

    localparam int STORE_DEPTH = 256;
    localparam int MAX_BURST   = 64;

    localparam int IDX_W  = $clog2(STORE_DEPTH);
    localparam int LEN_W  = $clog2(STORE_DEPTH + 1);
    localparam int CFG_W  = 9;
    localparam int SAT_W  = (LEN_W > CFG_W) ? LEN_W : CFG_W;
    localparam int CNT_W  = (LEN_W > 8) ? LEN_W : 8;
    localparam int BLEN_W = 7;
    localparam int BYTE_W = 8;

    localparam logic [LEN_W-1:0] LEN_MIN   = LEN_W'(2);
    localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(STORE_DEPTH);
    localparam logic [LEN_W-1:0] LEN_RESET =
        LEN_W'((STORE_DEPTH < 256) ? STORE_DEPTH : 256);
    localparam logic [BLEN_W-1:0] BURST_MAX = BLEN_W'(MAX_BURST);

    typedef enum logic [1:0] {
        OP_PUSH   = 2'd0,
        OP_POP    = 2'd1,
        OP_BURST  = 2'd2,
        OP_STATUS = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic {
        S_IDLE  = 1'b0,
        S_BURST = 1'b1
    } state_t;

    // Ring position: both indices and the length in use.
    typedef struct packed {
        logic [IDX_W-1:0] rd;
        logic [IDX_W-1:0] wr;
        logic [LEN_W-1:0] len;
    } ptr_t;

    // Occupancy figures derived from the ring position.
    typedef struct packed {
        logic [CNT_W-1:0] avail;
        logic [CNT_W-1:0] free;
        logic [CNT_W-1:0] contig;
        logic             empty;
        logic             full;
    } count_t;

    // One request to the byte store.
    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } ram_req_t;

    // Registered result control; the popped byte comes straight from the store.
    typedef struct packed {
        logic    strobe;
        logic    from_ram;
        status_t status;
        logic    last;
    } res_t;

    function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] ix,
                                                  input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] inc;
        inc = LEN_W'(ix) + LEN_W'(1);
        return (inc >= len) ? '0 : inc[IDX_W-1:0];
    endfunction

    function automatic logic [LEN_W-1:0] sat_len(input logic [CFG_W-1:0] v);
        logic [SAT_W-1:0] wide;
        wide = SAT_W'(v);
        if (wide < SAT_W'(LEN_MIN))
            return LEN_MIN;
        if (wide > SAT_W'(LEN_MAX))
            return LEN_MAX;
        return wide[LEN_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/brf_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
`default_nettype none

module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: rtl/core/brf_count.sv
// Occupancy arithmetic: available, free and contiguous byte counts.
`default_nettype none

module brf_count (
    input  wire brf_pkg::ptr_t   ptr,
    output brf_pkg::count_t      cnt
);

    import brf_pkg::*;

    logic [LEN_W-1:0] rd_w;
    logic [LEN_W-1:0] wr_w;
    logic [LEN_W-1:0] used;
    logic [LEN_W-1:0] to_end;
    logic [LEN_W-1:0] contig;

    always_comb
    begin
        rd_w = LEN_W'(ptr.rd);
        wr_w = LEN_W'(ptr.wr);
        if (wr_w >= rd_w)
            used = wr_w - rd_w;
        else
            used = ptr.len - (rd_w - wr_w);
        to_end = ptr.len - rd_w;
        if (used == '0)
            contig = '0;
        else if (used < to_end)
            contig = used;
        else
            contig = to_end;

        cnt.avail  = CNT_W'(used);
        cnt.free   = CNT_W'(ptr.len - used - LEN_W'(1));
        cnt.contig = CNT_W'(contig);
        cnt.empty  = (used == '0);
        cnt.full   = (used >= ptr.len - LEN_W'(1));
    end

endmodule

`default_nettype wire

FILE: rtl/core/brf_ctrl.sv
// Command sequencer: ring indices, length register, store requests and result flags.
`default_nettype none

module brf_ctrl (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [1:0]                    opcode,
    input  wire logic [brf_pkg::BYTE_W-1:0]    data_in,
    input  wire logic [brf_pkg::BLEN_W-1:0]    burst_len,
    input  wire logic                          cfg_valid,
    input  wire logic [brf_pkg::CFG_W-1:0]     cfg_data,
    input  wire brf_pkg::count_t               cnt,
    output logic                               busy,
    output logic                               cfg_ready,
    output brf_pkg::ptr_t                      ptr,
    output brf_pkg::ram_req_t                  ram_req,
    output brf_pkg::res_t                      res
);

    import brf_pkg::*;

    state_t            state_reg,  state_next;
    logic [IDX_W-1:0]  rd_reg,     rd_next;
    logic [IDX_W-1:0]  wr_reg,     wr_next;
    logic [LEN_W-1:0]  len_reg,    len_next;
    logic [BLEN_W-1:0] remain_reg, remain_next;
    logic              strobe_reg, strobe_next;
    logic              from_ram_reg, from_ram_next;
    status_t           status_reg, status_next;
    logic              last_reg,   last_next;

    logic [BLEN_W-1:0] blen_sat;
    logic [BLEN_W-1:0] burst_n;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            rd_reg       <= '0;
            wr_reg       <= '0;
            len_reg      <= LEN_RESET;
            remain_reg   <= '0;
            strobe_reg   <= 1'b0;
            from_ram_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_reg       <= rd_next;
            wr_reg       <= wr_next;
            len_reg      <= len_next;
            remain_reg   <= remain_next;
            strobe_reg   <= strobe_next;
            from_ram_reg <= from_ram_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        last_reg   <= last_next;
    end

    always_comb
    begin
        blen_sat = (burst_len > BURST_MAX) ? BURST_MAX : burst_len;
        if (CNT_W'(blen_sat) > cnt.avail)
            burst_n = cnt.avail[BLEN_W-1:0];
        else
            burst_n = blen_sat;
    end

    always_comb
    begin
        state_next    = state_reg;
        rd_next       = rd_reg;
        wr_next       = wr_reg;
        len_next      = len_reg;
        remain_next   = remain_reg;
        strobe_next   = 1'b0;
        from_ram_next = 1'b0;
        status_next   = ST_OK;
        last_next     = 1'b1;

        ram_req.we    = 1'b0;
        ram_req.waddr = wr_reg;
        ram_req.wdata = data_in;
        ram_req.re    = 1'b0;
        ram_req.raddr = rd_reg;

        busy      = (state_reg == S_BURST);
        cfg_ready = (state_reg == S_IDLE) && !start;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    strobe_next = 1'b1;
                    case (opcode_t'(opcode))
                        OP_PUSH:
                        begin
                            if (cnt.full)
                            begin
                                status_next = ST_FULL;
                            end
                            else
                            begin
                                ram_req.we = 1'b1;
                                wr_next    = next_idx(wr_reg, len_reg);
                            end
                        end
                        OP_POP:
                        begin
                            if (cnt.empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                ram_req.re    = 1'b1;
                                rd_next       = next_idx(rd_reg, len_reg);
                                from_ram_next = 1'b1;
                            end
                        end
                        OP_BURST:
                        begin
                            if (cnt.empty)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else if (burst_len != '0)
                            begin
                                // The first byte is read right away; the rest follow
                                // one per cycle from the burst state.
                                ram_req.re    = 1'b1;
                                rd_next       = next_idx(rd_reg, len_reg);
                                from_ram_next = 1'b1;
                                last_next     = (burst_n == BLEN_W'(1));
                                if (burst_n != BLEN_W'(1))
                                begin
                                    remain_next = burst_n - BLEN_W'(1);
                                    state_next  = S_BURST;
                                end
                            end
                        end
                        default:
                        begin
                            status_next = ST_OK;
                        end
                    endcase
                end
                else if (cfg_valid)
                begin
                    len_next = sat_len(cfg_data);
                    rd_next  = '0;
                    wr_next  = '0;
                end
            end
            S_BURST:
            begin
                ram_req.re    = 1'b1;
                rd_next       = next_idx(rd_reg, len_reg);
                strobe_next   = 1'b1;
                from_ram_next = 1'b1;
                last_next     = (remain_reg == BLEN_W'(1));
                remain_next   = remain_reg - BLEN_W'(1);
                if (remain_reg == BLEN_W'(1))
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign ptr.rd  = rd_reg;
    assign ptr.wr  = wr_reg;
    assign ptr.len = len_reg;

    assign res.strobe   = strobe_reg;
    assign res.from_ram = from_ram_reg;
    assign res.status   = status_reg;
    assign res.last     = last_reg;

endmodule

`default_nettype wire

FILE: rtl/core/byte_ring_fifo_unit.sv
// Top level of the byte ring FIFO: sequencer, byte store and occupancy counts.
//
//   channel   | signals                                         | transfer
//   ----------+-------------------------------------------------+---------------------------
//   command   | start, busy, opcode, data_in, burst_len         | start high while busy low
//   config    | cfg_valid, cfg_ready, cfg_data                  | cfg_valid and cfg_ready high
//   result    | strobe, data_out, status, avail_count,          | strobe high, one cycle
//             | free_count, contiguous_count, last              |
//
// Push, pop and status requests may be issued back to back; the result shows in
// the cycle after the request is taken.
// A pop burst of N bytes gives N results on consecutive cycles, one byte per cycle,
// set by the single read port of the byte store; busy is high with all but the last.
// Reset empties the ring and sets the length to its maximum; the store itself is not
// cleared. The result side has no stall: every result is taken in its strobe cycle.
`default_nettype none

module byte_ring_fifo_unit (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    opcode,
    input  wire logic [brf_pkg::BYTE_W-1:0]    data_in,
    input  wire logic [brf_pkg::BLEN_W-1:0]    burst_len,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [brf_pkg::CFG_W-1:0]     cfg_data,
    output logic                               strobe,
    output logic [brf_pkg::BYTE_W-1:0]         data_out,
    output logic [1:0]                         status,
    output logic [7:0]                         avail_count,
    output logic [7:0]                         free_count,
    output logic [7:0]                         contiguous_count,
    output logic                               last
);

    import brf_pkg::*;

    ptr_t              ptr;
    count_t            cnt;
    ram_req_t          ram_req;
    res_t              res;
    logic [BYTE_W-1:0] rdata;

    brf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .opcode    (opcode),
        .data_in   (data_in),
        .burst_len (burst_len),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .cnt       (cnt),
        .busy      (busy),
        .cfg_ready (cfg_ready),
        .ptr       (ptr),
        .ram_req   (ram_req),
        .res       (res)
    );

    // Only one request is in flight per cycle, so a write and a read never meet
    // on the same entry in the same cycle.
    brf_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (rdata)
    );

    // The indices already hold the post-request position during the strobe cycle.
    brf_count u_count (
        .ptr (ptr),
        .cnt (cnt)
    );

    assign strobe           = res.strobe;
    assign data_out         = res.from_ram ? rdata : '0;
    assign status           = res.status;
    assign last             = res.last;
    assign avail_count      = cnt.avail[7:0];
    assign free_count       = cnt.free[7:0];
    assign contiguous_count = cnt.contig[7:0];

endmodule

`default_nettype wire

FILE: rtl/core/brf_checker.sv
// Port-level checker for the byte ring FIFO, bound to the top level.
`default_nettype none

module brf_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       start,
    input wire logic       busy,
    input wire logic       strobe,
    input wire logic [7:0] data_out,
    input wire logic [1:0] status,
    input wire logic [7:0] avail_count,
    input wire logic [7:0] contiguous_count,
    input wire logic       last
);

    import brf_pkg::*;

    // Every accepted request produces a result on the next cycle.
    a_req_result: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> strobe)
        else $error("accepted request gave no result");

    // Burst results come on consecutive cycles until the last one.
    a_burst_run: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |=> strobe)
        else $error("burst result run broken");

    // While results of a burst are still owed, no new request can be taken.
    a_burst_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> busy)
        else $error("not busy with burst results pending");

    // An error result always ends its request.
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (status != ST_OK) |-> last && (data_out == 8'd0))
        else $error("error result not final or carries data");

    // An empty ring has nothing readable before the wrap point.
    a_empty_contig: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (avail_count == 8'd0) |-> (contiguous_count == 8'd0))
        else $error("contiguous count nonzero while empty");

endmodule

bind byte_ring_fifo_unit brf_checker u_brf_checker (.*);

`default_nettype wire

FILE: verif/byte_ring_fifo_unit_tb.sv
// Self-checking testbench for the byte ring FIFO: random and directed requests against a predictor.
`timescale 1ns / 1ps

module byte_ring_fifo_unit_tb;
    import brf_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        status_t    st;
        logic [7:0] avail;
        logic [7:0] free;
        logic [7:0] contig;
        logic       last;
    } fifo_result_t;

    // Tracks ring contents and indices, and holds the results still owed by the block.
    class ring_scoreboard;
        logic [7:0]   byte_mem [STORE_DEPTH];
        int           rd_ix;
        int           wr_ix;
        int           ring_len;
        int           errors;
        fifo_result_t pending_results [$];

        function new();
            rd_ix = 0;
            wr_ix = 0;
            ring_len = int'(LEN_RESET);
            errors = 0;
        endfunction

        function void set_length(logic [8:0] v);
            int l;
            l = int'(v);
            if (l < 2)
                l = 2;
            if (l > STORE_DEPTH)
                l = STORE_DEPTH;
            ring_len = l;
            rd_ix = 0;
            wr_ix = 0;
        endfunction

        function int used();
            if (wr_ix >= rd_ix)
                return wr_ix - rd_ix;
            return ring_len - (rd_ix - wr_ix);
        endfunction

        function int step_ix(int ix);
            return (ix + 1 >= ring_len) ? 0 : ix + 1;
        endfunction

        function logic [7:0] take_byte();
            logic [7:0] b;
            b = byte_mem[rd_ix];
            rd_ix = step_ix(rd_ix);
            return b;
        endfunction

        // Counts are those after the action that this result reports.
        function void push_outcome(logic [7:0] d, status_t st, logic is_last);
            fifo_result_t r;
            int fill;
            fill = used();
            r.data = d;
            r.st = st;
            r.avail = 8'(fill);
            r.free = 8'(ring_len - fill - 1);
            r.contig = (fill == 0) ? 8'd0
                     : 8'((fill < ring_len - rd_ix) ? fill : ring_len - rd_ix);
            r.last = is_last;
            pending_results.push_back(r);
        endfunction

        function void note_request(opcode_t op, logic [7:0] d, logic [6:0] bl);
            int fill;
            int n;
            logic [7:0] b;
            fill = used();
            case (op)
                OP_PUSH:
                    if (fill >= ring_len - 1)
                        push_outcome(8'd0, ST_FULL, 1'b1);
                    else
                    begin
                        byte_mem[wr_ix] = d;
                        wr_ix = step_ix(wr_ix);
                        push_outcome(8'd0, ST_OK, 1'b1);
                    end
                OP_POP:
                    if (fill == 0)
                        push_outcome(8'd0, ST_EMPTY, 1'b1);
                    else
                    begin
                        b = take_byte();
                        push_outcome(b, ST_OK, 1'b1);
                    end
                OP_BURST:
                    if (fill == 0)
                        push_outcome(8'd0, ST_EMPTY, 1'b1);
                    else if (bl == 7'd0)
                        push_outcome(8'd0, ST_OK, 1'b1);
                    else
                    begin
                        n = (int'(bl) > MAX_BURST) ? MAX_BURST : int'(bl);
                        if (n > fill)
                            n = fill;
                        for (int k = 0; k < n; k++)
                        begin
                            b = take_byte();
                            push_outcome(b, ST_OK, k == n - 1);
                        end
                    end
                default:
                    push_outcome(8'd0, ST_OK, 1'b1);
            endcase
        endfunction

        function void report(string field, logic [7:0] want, logic [7:0] got);
            if (got !== want)
            begin
                errors++;
                $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
            end
        endfunction

        function void check_result(logic [7:0] d, logic [1:0] st, logic [7:0] av,
                                   logic [7:0] fr, logic [7:0] co, logic la);
            fifo_result_t want;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: result with none expected: data %0d status %0d",
                         $time, d, st);
                return;
            end
            want = pending_results.pop_front();
            report("data_out", want.data, d);
            report("status", 8'(want.st), 8'(st));
            report("avail_count", want.avail, av);
            report("free_count", want.free, fr);
            report("contiguous_count", want.contig, co);
            report("last", 8'(want.last), 8'(la));
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  opcode = 2'd0;
    logic [7:0]  data_in = 8'd0;
    logic [6:0]  burst_len = 7'd0;
    logic        cfg_valid = 1'b0;
    logic [8:0]  cfg_data = 9'd0;
    logic        busy;
    logic        cfg_ready;
    logic        strobe;
    logic [7:0]  data_out;
    logic [1:0]  status;
    logic [7:0]  avail_count;
    logic [7:0]  free_count;
    logic [7:0]  contiguous_count;
    logic        last;

    ring_scoreboard sb;
    bit             quiet = 1'b0;

    byte_ring_fifo_unit dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .opcode           (opcode),
        .data_in          (data_in),
        .burst_len        (burst_len),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_data         (cfg_data),
        .strobe           (strobe),
        .data_out         (data_out),
        .status           (status),
        .avail_count      (avail_count),
        .free_count       (free_count),
        .contiguous_count (contiguous_count),
        .last             (last)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n && strobe)
            sb.check_result(data_out, status, avail_count, free_count, contiguous_count, last);
    end

    // Holds start high from one request to the next when no gap is drawn.
    task automatic send_cmd(opcode_t op, logic [7:0] d, logic [6:0] bl);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        opcode <= op;
        data_in <= d;
        burst_len <= bl;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_request(op, d, bl);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_length(logic [8:0] v);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_length(v);
    endtask

    task automatic run_phase(int count, int push_pct, int blen_hi);
        int       r;
        opcode_t  op;
        logic [6:0] bl;
        repeat (count)
        begin
            r = $urandom_range(0, 99);
            if (r < push_pct)
                op = OP_PUSH;
            else
            begin
                r = $urandom_range(0, 99);
                op = (r < 40) ? OP_POP : (r < 85) ? OP_BURST : OP_STATUS;
            end
            bl = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, blen_hi))
                                             : 7'($urandom_range(1, 8));
            // Now and then the sender holds off until the block has caught up.
            if ($urandom_range(0, 47) == 0)
                wait_drained();
            send_cmd(op, 8'($urandom), bl);
        end
    endtask

    initial
    begin
        int sel;
        logic [8:0] len;
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty ring at full length, then bursts of zero, oversize and clipped length.
        send_cmd(OP_STATUS, 8'h00, 7'd0);
        send_cmd(OP_POP, 8'h00, 7'd0);
        send_cmd(OP_BURST, 8'h00, 7'd5);
        send_cmd(OP_BURST, 8'hFF, 7'd0);
        send_cmd(OP_PUSH, 8'h00, 7'd0);
        send_cmd(OP_PUSH, 8'hFF, 7'd127);
        send_cmd(OP_PUSH, 8'h5A, 7'd1);
        send_cmd(OP_BURST, 8'h00, 7'd0);
        send_cmd(OP_BURST, 8'h00, 7'd127);
        send_cmd(OP_PUSH, 8'hA5, 7'd64);
        send_cmd(OP_POP, 8'h00, 7'd0);
        send_cmd(OP_STATUS, 8'hFF, 7'd127);

        // Lengths below the minimum saturate to two slots, a single byte of room.
        write_length(9'd0);
        send_cmd(OP_PUSH, 8'h11, 7'd0);
        send_cmd(OP_PUSH, 8'h22, 7'd0);
        send_cmd(OP_STATUS, 8'h00, 7'd0);
        send_cmd(OP_BURST, 8'h00, 7'd64);
        send_cmd(OP_POP, 8'h00, 7'd0);
        write_length(9'd1);
        send_cmd(OP_PUSH, 8'h80, 7'd0);
        send_cmd(OP_POP, 8'h00, 7'd0);
        write_length(9'd3);
        send_cmd(OP_PUSH, 8'h01, 7'd0);
        send_cmd(OP_PUSH, 8'h7F, 7'd0);
        send_cmd(OP_PUSH, 8'hFE, 7'd0);
        send_cmd(OP_BURST, 8'h00, 7'd65);
        send_cmd(OP_STATUS, 8'h00, 7'd0);

        // Largest ring: fill past full, wrap the write index, then drain in bursts.
        write_length(9'h1FF);
        run_phase(258, 100, 127);
        run_phase(40, 60, 127);
        while (sb.used() != 0)
            send_cmd(OP_BURST, 8'($urandom), 7'd64);

        for (int p = 0; p < 10; p++)
        begin
            sel = $urandom_range(0, 4);
            case (sel)
                0: len = 9'($urandom_range(2, 8));
                1: len = 9'($urandom_range(9, 40));
                2: len = 9'($urandom_range(0, 1));
                3: len = 9'($urandom_range(257, 511));
                default: len = 9'($urandom_range(41, 255));
            endcase
            write_length(len);
            quiet = ($urandom_range(0, 2) == 0);
            run_phase(14, $urandom_range(35, 75), 127);
        end
        write_length(9'd256);
        quiet = 1'b0;
        run_phase(12, 50, 127);

        start <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (sb.errors == 0 && sb.pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
